FILE: hw/rtl/rwc_pkg.sv
// Shared widths, constants and controller command type for the RGB332 window convolver.
package rwc_pkg;

  localparam int PIX_W   = 8;
  localparam int WGT_W   = 16;
  localparam int DIV_W   = 16;
  localparam int ACC_W   = 32;
  localparam int CH_W    = 3;
  localparam int PROD_W  = WGT_W + CH_W;
  localparam int NUM_W   = ACC_W + 1;
  localparam int NLANE   = 3;
  localparam int SHIFT_W = 2;

  // Lane order matches the packing of the RGB332 byte from the low bits up.
  localparam int LANE_BLUE  = 0;
  localparam int LANE_GREEN = 1;
  localparam int LANE_RED   = 2;

  localparam logic [CH_W-1:0]    BLUE_MAX   = 3'd3;
  localparam logic [CH_W-1:0]    CH_MAX     = 3'd7;
  localparam logic [SHIFT_W-1:0] STEP_FIRST = 2'd3;
  localparam logic [SHIFT_W-1:0] STEP_LAST  = 2'd0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                acc_en;
    logic                acc_last;
    logic                load;
    logic                step;
    logic [SHIFT_W-1:0]  shift;
    logic                out_load;
  } cmd_t;

endpackage

FILE: hw/rtl/rwc_ctrl.sv
// Controller state machine: beat acceptance, finishing sequence and output valid.
module rwc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  input  logic          s_axis_tlast,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output rwc_pkg::cmd_t cmd
);

  typedef enum logic [1:0] {
    IDLE,
    LOAD,
    STEP,
    DONE
  } state_t;

  state_t                       state;
  logic [rwc_pkg::SHIFT_W-1:0]  shift;
  logic                         out_free;

  // Beats are taken only while no window is being finished.
  assign s_axis_tready = (state == IDLE);
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    cmd          = '0;
    cmd.acc_en   = (state == IDLE) && s_axis_tvalid;
    cmd.acc_last = s_axis_tlast;
    cmd.load     = (state == LOAD);
    cmd.step     = (state == STEP);
    cmd.shift    = shift;
    cmd.out_load = (state == DONE) && out_free;
  end

  // State, step counter and output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      shift         <= rwc_pkg::STEP_FIRST;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Output valid rises when a result is loaded and falls when its beat is taken.
      if ((state == DONE) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (s_axis_tvalid && s_axis_tlast) begin
            state <= LOAD;
          end
        end
        LOAD: begin
          state <= STEP;
          shift <= rwc_pkg::STEP_FIRST;
        end
        STEP: begin
          if (shift == rwc_pkg::STEP_LAST) begin
            state <= DONE;
          end else begin
            shift <= shift - 1'b1;
          end
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // A finished result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded while previous result pending");

  // A last beat always starts the finishing sequence.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> (state == LOAD))
    else $error("last beat did not start finishing");

  // The division steps always begin at the saturation check.
  a_step_start: assert property (@(posedge clk) disable iff (rst)
    (state == LOAD) |=> (state == STEP && shift == rwc_pkg::STEP_FIRST))
    else $error("division steps started at wrong shift");

endmodule

FILE: hw/rtl/rwc_datapath.sv
// Datapath: channel multiply-accumulate, rounding, shift-subtract division and clamping.
module rwc_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  rwc_pkg::cmd_t               cmd,
  input  logic [rwc_pkg::PIX_W-1:0]   pixel,
  input  logic signed [rwc_pkg::WGT_W-1:0] weight,
  input  logic                        cfg_we,
  input  logic [rwc_pkg::DIV_W-1:0]   cfg_wdata,
  output logic [rwc_pkg::PIX_W-1:0]   result_pixel
);

  localparam int LN = rwc_pkg::NLANE;

  logic [rwc_pkg::DIV_W-1:0]  divisor;
  logic [rwc_pkg::DIV_W-1:0]  div_eff;
  logic [rwc_pkg::ACC_W-1:0]  acc [LN];
  logic [rwc_pkg::ACC_W-1:0]  fin [LN];
  logic [rwc_pkg::ACC_W-1:0]  rem [LN];
  logic                       neg [LN];
  logic                       sat [LN];
  logic [rwc_pkg::CH_W-1:0]   quo [LN];

  logic [rwc_pkg::CH_W-1:0]   ch       [LN];
  logic signed [rwc_pkg::PROD_W-1:0] prod [LN];
  logic [rwc_pkg::ACC_W-1:0]  acc_sum  [LN];
  logic [rwc_pkg::NUM_W-1:0]  num      [LN];
  logic [rwc_pkg::ACC_W-1:0]  dshift;
  logic                       ge       [LN];
  logic [rwc_pkg::CH_W-1:0]   q_clamp  [LN];

  // Divisor register; zero acts as one.
  always_ff @(posedge clk) begin
    if (rst) begin
      divisor <= {{(rwc_pkg::DIV_W-1){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      divisor <= cfg_wdata;
    end
  end

  assign div_eff = (divisor == '0) ? {{(rwc_pkg::DIV_W-1){1'b0}}, 1'b1} : divisor;
  assign dshift  = {{(rwc_pkg::ACC_W-rwc_pkg::DIV_W){1'b0}}, div_eff} << cmd.shift;

  // Channel split of the RGB332 byte.
  assign ch[rwc_pkg::LANE_BLUE]  = {1'b0, pixel[1:0]};
  assign ch[rwc_pkg::LANE_GREEN] = pixel[4:2];
  assign ch[rwc_pkg::LANE_RED]   = pixel[7:5];

  // Per-lane arithmetic: product, running sum, rounded numerator, step compare.
  always_comb begin
    for (int i = 0; i < LN; i++) begin
      prod[i]    = weight * $signed({1'b0, ch[i]});
      acc_sum[i] = acc[i] + {{(rwc_pkg::ACC_W-rwc_pkg::PROD_W){prod[i][rwc_pkg::PROD_W-1]}},
                             prod[i]};
      num[i]     = {fin[i][rwc_pkg::ACC_W-1], fin[i]}
                 + {{(rwc_pkg::NUM_W-rwc_pkg::DIV_W+1){1'b0}},
                    div_eff[rwc_pkg::DIV_W-1:1]};
      ge[i]      = (rem[i] >= dshift);
    end
  end

  // Accumulators clear on the last beat; the window total moves to the finishing register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LN; i++) begin
        acc[i] <= '0;
      end
    end else if (cmd.acc_en) begin
      for (int i = 0; i < LN; i++) begin
        acc[i] <= cmd.acc_last ? '0 : acc_sum[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en && cmd.acc_last) begin
      for (int i = 0; i < LN; i++) begin
        fin[i] <= acc_sum[i];
      end
    end
  end

  // Restoring division, one quotient bit per step. The first step only checks whether
  // the quotient reaches eight, which saturates that channel.
  always_ff @(posedge clk) begin
    for (int i = 0; i < LN; i++) begin
      if (cmd.load) begin
        neg[i] <= num[i][rwc_pkg::NUM_W-1];
        rem[i] <= num[i][rwc_pkg::ACC_W-1:0];
        sat[i] <= 1'b0;
        quo[i] <= '0;
      end else if (cmd.step) begin
        if (cmd.shift == rwc_pkg::STEP_FIRST) begin
          sat[i] <= ge[i];
        end else if (ge[i]) begin
          rem[i]            <= rem[i] - dshift;
          quo[i][cmd.shift] <= 1'b1;
        end
      end
    end
  end

  // Clamp: negative quotients give zero, saturated ones the channel maximum; blue is capped at three.
  always_comb begin
    for (int i = 0; i < LN; i++) begin
      if (neg[i]) begin
        q_clamp[i] = '0;
      end else if (sat[i]) begin
        q_clamp[i] = rwc_pkg::CH_MAX;
      end else begin
        q_clamp[i] = quo[i];
      end
    end
    if (q_clamp[rwc_pkg::LANE_BLUE] > rwc_pkg::BLUE_MAX) begin
      q_clamp[rwc_pkg::LANE_BLUE] = rwc_pkg::BLUE_MAX;
    end
  end

  // Output register holds the packed pixel until the beat is taken.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result_pixel <= {q_clamp[rwc_pkg::LANE_RED], q_clamp[rwc_pkg::LANE_GREEN],
                       q_clamp[rwc_pkg::LANE_BLUE][1:0]};
    end
  end

endmodule

FILE: hw/rtl/rgb332_window_convolve.sv
// Top level of the RGB332 window convolver: controller and datapath.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata[7:0] pixel, tdata[23:8] weight, tlast end of window
//   m_axis   out        tdata[7:0] result_pixel
//   cfg      in         cfg_wdata[15:0] divisor, written when cfg_we is high
//
// Beats that are not the last of a window are taken while no window is being finished; the
// multiply-accumulate of all three channels happens at the accepting edge.
// The last beat starts a finishing sequence in the serial divider (rounding load, four
// shift-subtract division steps, output load).
// A finished result waits in the output register; beats of the next window are
// accepted meanwhile, and finishing stalls only if the previous result is untaken.
// Reset clears the accumulators and sets the divisor to one; no clearing pass.
module rgb332_window_convolve (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] pixel, [23:8] weight
  input  logic        s_axis_tlast,   // last beat of the window
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] result_pixel
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata       // [15:0] divisor
);

  rwc_pkg::cmd_t cmd;

  rwc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cmd           (cmd)
  );

  rwc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .pixel        (s_axis_tdata[7:0]),
    .weight       (s_axis_tdata[23:8]),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_pixel (m_axis_tdata)
  );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the RGB332 window convolver, with a stream driver and a predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W = rwc_pkg::PIX_W;
  localparam int WGT_W = rwc_pkg::WGT_W;
  localparam int DIV_W = rwc_pkg::DIV_W;
  localparam int ACC_W = rwc_pkg::ACC_W;
  localparam int CH_W  = rwc_pkg::CH_W;
  localparam logic [CH_W-1:0] BLUE_MAX = rwc_pkg::BLUE_MAX;
  localparam logic [CH_W-1:0] CH_MAX   = rwc_pkg::CH_MAX;

  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_GAP       = 9;
  localparam int LONG_HOLD     = 400;
  localparam int PHASE_BEATS   = 180;
  localparam int NUM_PHASES    = 10;

  // Ways of drawing the kernel weights of one random window.
  typedef enum int {W_SMALL, W_BYTE, W_FULL, W_SCALED} weight_style_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [WGT_W-1:0] weight;
    logic             end_of_window;
  } window_beat_t;

  // Accumulates each window and queues the filtered pixel it should produce.
  class filter_scoreboard;
    logic [ACC_W-1:0] blue_acc;
    logic [ACC_W-1:0] green_acc;
    logic [ACC_W-1:0] red_acc;
    logic [DIV_W-1:0] divisor;
    logic [PIX_W-1:0] pending_pixels[$];
    int               errors;
    int               results_seen;

    function new();
      blue_acc     = '0;
      green_acc    = '0;
      red_acc      = '0;
      divisor      = 1;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_divisor(input logic [DIV_W-1:0] value);
      divisor = value;
    endfunction

    function int pending();
      return pending_pixels.size();
    endfunction

    // Rounding add, division toward zero and clamp of one channel sum.
    function logic [CH_W-1:0] normalize(input logic [ACC_W-1:0] acc,
                                        input logic [CH_W-1:0] top);
      longint num;
      longint den;
      longint q;
      num = longint'($signed(acc));
      den = (divisor == '0) ? 64'sd1 : longint'(divisor);
      q = (num + den / 2) / den;
      if (q < 0) q = 0;
      if (q > longint'(top)) q = longint'(top);
      return CH_W'(q);
    endfunction

    // Multiply-accumulate of one accepted beat; the window end yields a pixel.
    function void note_beat(input window_beat_t b);
      longint           w;
      logic [CH_W-1:0]  blue_ch;
      logic [CH_W-1:0]  green_ch;
      logic [CH_W-1:0]  red_ch;
      w = longint'($signed(b.weight));
      blue_acc  += ACC_W'(w * longint'(b.pixel[1:0]));
      green_acc += ACC_W'(w * longint'(b.pixel[4:2]));
      red_acc   += ACC_W'(w * longint'(b.pixel[7:5]));
      if (b.end_of_window) begin
        blue_ch  = normalize(blue_acc, BLUE_MAX);
        green_ch = normalize(green_acc, CH_MAX);
        red_ch   = normalize(red_acc, CH_MAX);
        pending_pixels.push_back({red_ch, green_ch, blue_ch[1:0]});
        blue_acc  = '0;
        green_acc = '0;
        red_acc   = '0;
      end
    endfunction

    // Compares one output beat with the oldest predicted pixel.
    function void check_result(input logic [PIX_W-1:0] got);
      logic [PIX_W-1:0] want;
      results_seen++;
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: result_pixel with nothing pending: expected none, actual 0x%02h",
                 $time, got);
        return;
      end
      want = pending_pixels.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: result_pixel mismatch: expected 0x%02h, actual 0x%02h",
                 $time, want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] pixel, [23:8] weight
  logic        s_axis_tlast;   // last beat of the window
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] result_pixel
  logic        cfg_we;
  logic [15:0] cfg_wdata;      // [15:0] divisor

  filter_scoreboard sb = new();
  bit               tx_burst;
  logic [DIV_W-1:0] phase_divisors[NUM_PHASES];

  rgb332_window_convolve dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Idle cycles before a beat: none during a burst, otherwise random.
  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Offers one beat and waits for it to be taken.
  task automatic send_beat(input window_beat_t b);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.weight, b.pixel};
    s_axis_tlast  <= b.end_of_window;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_beat(b);
  endtask

  task automatic send_one(input logic [PIX_W-1:0] pixel, input logic [WGT_W-1:0] weight,
                          input logic end_of_window);
    window_beat_t b;
    b.pixel         = pixel;
    b.weight        = weight;
    b.end_of_window = end_of_window;
    send_beat(b);
  endtask

  // One window of random pixels, weights drawn in the given style.
  task automatic send_window(input int len, input weight_style_t style);
    window_beat_t b;
    int           span;
    span = 2 * ((sb.divisor == '0) ? 1 : int'(sb.divisor)) / len + 1;
    if (span > 32767) span = 32767;
    for (int i = 0; i < len; i++) begin
      b.pixel = PIX_W'($urandom_range(0, 255));
      case (style)
        W_SMALL: b.weight = WGT_W'($urandom_range(0, 16) - 8);
        W_BYTE:  b.weight = WGT_W'($urandom_range(0, 255));
        W_FULL:  b.weight = WGT_W'($urandom());
        default: b.weight = WGT_W'($urandom_range(0, span));
      endcase
      b.end_of_window = (i == len - 1);
      send_beat(b);
    end
  endtask

  // Mostly short windows, now and then one of up to 64 beats.
  task automatic run_random_phase(input int n_beats);
    int sent;
    int len;
    sent = 0;
    while (sent < n_beats) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 64) : $urandom_range(1, 9);
      tx_burst = ($urandom_range(0, 3) == 0);
      send_window(len, weight_style_t'($urandom_range(0, 3)));
      sent += len;
    end
    tx_burst = 1'b0;
  endtask

  // Holds the input idle until every predicted pixel has come out.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_divisor(input logic [DIV_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_divisor(value);
  endtask

  // Stimulus: directed windows, then random phases.
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    tx_burst      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Extreme pixels and weights with unit divisor.
    write_divisor(16'd1);
    send_one(8'hFF, 16'h7FFF, 1'b1);
    send_one(8'hFF, 16'h8000, 1'b1);
    send_one(8'h00, 16'h7FFF, 1'b1);
    send_one(8'hA5, 16'h0001, 1'b0);
    send_one(8'h5A, 16'h0001, 1'b1);
    send_one(8'h6D, 16'h0001, 1'b1);
    drain_results();

    // A zero divisor behaves as one.
    write_divisor(16'd0);
    send_one(8'h6D, 16'h0001, 1'b1);
    send_one(8'hFF, 16'h0000, 1'b1);
    drain_results();

    // Largest divisor: only huge sums survive the division.
    write_divisor(16'hFFFF);
    send_one(8'hFF, 16'h7FFF, 1'b0);
    send_one(8'hFF, 16'h7FFF, 1'b1);
    send_one(8'hFF, 16'h8000, 1'b1);
    drain_results();

    // Rounding with small divisors, positive and negative sums.
    write_divisor(16'd2);
    send_one(8'h01, 16'h0001, 1'b1);
    send_one(8'h01, 16'hFFFF, 1'b1);
    send_one(8'h03, 16'hFFFD, 1'b1);
    drain_results();
    write_divisor(16'd3);
    send_one(8'h49, 16'h0005, 1'b1);
    send_one(8'h92, 16'h0002, 1'b0);
    send_one(8'h24, 16'hFFFE, 1'b1);
    drain_results();

    // Random phases, one divisor setting each.
    phase_divisors = '{16'd1, 16'd0, 16'hFFFF, 16'd9, 16'd16, 16'd3,
                       DIV_W'($urandom_range(1, 65535)), DIV_W'($urandom_range(1, 255)),
                       16'd2, 16'd1};
    foreach (phase_divisors[i]) begin
      drain_results();
      write_divisor(phase_divisors[i]);
      run_random_phase(PHASE_BEATS);
    end
    drain_results();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Result side: random stalls, zero-stall stretches and one long hold-off.
  initial begin : result_sink
    int hold_left;
    bit long_hold_done;
    bit rx_burst;
    hold_left      = 0;
    long_hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
        rx_burst = ((sb.results_seen / 40) % 4 == 1);
        if (!long_hold_done && sb.results_seen == 30) begin
          hold_left      = LONG_HOLD;
          long_hold_done = 1'b1;
        end else begin
          hold_left = draw_gap(rx_burst);
        end
      end
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #10ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
